// File: rtl/core/eapol_m1_pkg.sv
// Shared types and constants for the EAPOL message-one and PMKID detector.
`default_nettype none
package eapol_m1_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 4096;
    localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned CMP_W = ((POS_W > 16) ? POS_W : 16) + 1;

    localparam logic [7:0] SNAP_HDR [8] = '{
        8'hAA, 8'hAA, 8'h03, 8'h00, 8'h00, 8'h00, 8'h88, 8'h8E
    };

    localparam logic [7:0]  EAPOL_TYPE_KEY = 8'h03;
    localparam logic [15:0] KEY_INFO_ACK   = 16'h0080;
    localparam logic [15:0] KEY_INFO_MIC   = 16'h0100;
    localparam logic [47:0] PMKID_KDE_HDR  = 48'hDD14_000F_AC04;

    localparam int unsigned POS_SNAP_END   = 8;
    localparam int unsigned POS_EAPOL_TYPE = 9;
    localparam int unsigned POS_KEY_INFO_H = 13;
    localparam int unsigned POS_KEY_INFO_L = 14;
    localparam int unsigned POS_KDL_H      = 105;
    localparam int unsigned POS_KDL_L      = 106;
    localparam int unsigned POS_SCAN_START = 112;
    localparam int unsigned KEY_DATA_START = 107;
    localparam int unsigned MIN_M1_LEN     = 15;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] time_ms;
    } t_item;

    typedef struct packed {
        logic        is_message_one;
        logic        pmkid_present;
        logic [31:0] m1_time_ms;
    } t_result;

endpackage
`default_nettype wire

// File: rtl/core/eapol_m1_in_reg.sv
// Input register stage for the payload byte stream.
`default_nettype none
module eapol_m1_in_reg
    import eapol_m1_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    input  wire logic  i_advance,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/eapol_m1_frame_track.sv
// Per-frame parse state and the result computed at the last byte.
`default_nettype none
module eapol_m1_frame_track
    import eapol_m1_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_advance,
    input  wire t_item i_item,
    output t_result    o_result
);

    logic [POS_W-1:0] r_pos,        n_pos;
    logic [39:0]      r_recent,     n_recent;
    logic             r_hdr_good,   n_hdr_good;
    logic [15:0]      r_key_info,   n_key_info;
    logic [15:0]      r_kdl,        n_kdl;
    logic             r_found,      n_found;

    logic             over;
    logic [47:0]      window;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] kdl_ext;
    logic [CMP_W-1:0] scan_off;
    logic             m1;
    logic             pmkid;

    assign over     = (r_pos >= POS_W'(MAX_FRAME_BYTES));
    assign window   = {r_recent, i_item.data_byte};
    assign len_ext  = CMP_W'(r_pos) + CMP_W'(1);
    assign kdl_ext  = CMP_W'(r_kdl);
    assign scan_off = CMP_W'(r_pos) - CMP_W'(POS_KDL_L);

    always_comb begin
        n_pos      = r_pos;
        n_hdr_good = r_hdr_good;
        n_key_info = r_key_info;
        n_kdl      = r_kdl;
        n_found    = r_found;
        n_recent   = window[39:0];
        if (!over) begin
            if (r_pos < POS_W'(POS_SNAP_END)) begin
                if (i_item.data_byte != SNAP_HDR[r_pos[2:0]]) begin
                    n_hdr_good = 1'b0;
                end
            end else if (r_pos == POS_W'(POS_EAPOL_TYPE)) begin
                if (i_item.data_byte != EAPOL_TYPE_KEY) begin
                    n_hdr_good = 1'b0;
                end
            end else if (r_pos == POS_W'(POS_KEY_INFO_H)) begin
                n_key_info[15:8] = i_item.data_byte;
            end else if (r_pos == POS_W'(POS_KEY_INFO_L)) begin
                n_key_info[7:0] = i_item.data_byte;
            end else if (r_pos == POS_W'(POS_KDL_H)) begin
                n_kdl[15:8] = i_item.data_byte;
            end else if (r_pos == POS_W'(POS_KDL_L)) begin
                n_kdl[7:0] = i_item.data_byte;
            end
            // The key data length is settled long before the scan begins.
            if ((r_pos >= POS_W'(POS_SCAN_START)) && (scan_off <= kdl_ext) &&
                (window == PMKID_KDE_HDR)) begin
                n_found = 1'b1;
            end
            n_pos = r_pos + POS_W'(1);
        end
    end

    assign m1 = n_hdr_good && (over || (len_ext >= CMP_W'(MIN_M1_LEN))) &&
                ((n_key_info & KEY_INFO_ACK) != 16'h0000) &&
                ((n_key_info & KEY_INFO_MIC) == 16'h0000);
    assign pmkid = m1 && !over && (len_ext >= CMP_W'(KEY_DATA_START)) &&
                   (n_kdl != 16'h0000) &&
                   ((CMP_W'(KEY_DATA_START) + CMP_W'(n_kdl)) <= len_ext) && n_found;

    always_comb begin
        o_result.is_message_one = m1;
        o_result.pmkid_present  = pmkid;
        o_result.m1_time_ms     = m1 ? i_item.time_ms : 32'h0000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_recent   <= '0;
            r_hdr_good <= 1'b1;
            r_key_info <= '0;
            r_kdl      <= '0;
            r_found    <= 1'b0;
        end else if (i_advance) begin
            if (i_item.last_byte) begin
                r_pos      <= '0;
                r_recent   <= '0;
                r_hdr_good <= 1'b1;
                r_key_info <= '0;
                r_kdl      <= '0;
                r_found    <= 1'b0;
            end else begin
                r_pos      <= n_pos;
                r_recent   <= n_recent;
                r_hdr_good <= n_hdr_good;
                r_key_info <= n_key_info;
                r_kdl      <= n_kdl;
                r_found    <= n_found;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/eapol_m1_out_reg.sv
// Result register that holds one frame verdict until it is taken.
`default_nettype none
module eapol_m1_out_reg
    import eapol_m1_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_ready,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load || (r_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/eapol_m1_pmkid_detector_core.sv
// Top level of the EAPOL message-one and PMKID detector.
`default_nettype none
// The block takes the payload of one data frame, one byte per transfer, starting right
// after the 802.11 header, with the final byte flagged by last_byte. It checks the
// LLC/SNAP header with EtherType 0x888E and EAPOL type 3 (key), reads the key information
// word at bytes 13 and 14 and the key data length at bytes 105 and 106, and scans the key
// data with a six-byte window for the PMKID KDE header DD 14 00 0F AC 04. Exactly one
// result transfer is produced per frame, at its last byte: is_message_one is set when ACK
// is set and MIC is clear, pmkid_present when a KDE match lies wholly inside non-empty key
// data that fits in the frame, and m1_time_ms carries the last byte's timestamp for a
// message one and zero otherwise. Frames longer than 4096 bytes can still report message
// one but never a PMKID. Each byte is registered at the input, the parse state is updated
// by a single compare-and-update step, and a last byte writes the result register, so a new
// byte is accepted every cycle unless the input stalls. The result register is loaded at the
// edge that takes the last byte. Input only stalls when a last byte meets a result that is
// still waiting to be taken.
module eapol_m1_pmkid_detector_core
    import eapol_m1_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic [31:0] i_time_ms,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_is_message_one,
    output logic             o_pmkid_present,
    output logic [31:0]      o_m1_time_ms
);

    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    advance;
    t_result frame_result;
    t_result out_result;

    assign in_item.data_byte = i_data_byte;
    assign in_item.last_byte = i_last_byte;
    assign in_item.time_ms   = i_time_ms;

    // A byte in the input register moves on unless it is a last byte and the result
    // register is still occupied by a verdict that is not being taken this cycle.
    assign advance = stage_valid &&
                     (!stage_item.last_byte || !o_out_valid || i_out_ready);

    eapol_m1_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    eapol_m1_frame_track u_frame_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (stage_item),
        .o_result  (frame_result)
    );

    eapol_m1_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && stage_item.last_byte),
        .i_result (frame_result),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_is_message_one = out_result.is_message_one;
    assign o_pmkid_present  = out_result.pmkid_present;
    assign o_m1_time_ms     = out_result.m1_time_ms;

`ifndef SYNTH
    // A PMKID can only be reported for a frame that is message one.
    a_pmkid_needs_m1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_message_one || !o_pmkid_present))
        else $error("pmkid_present without is_message_one");

    // The timestamp is zero whenever the frame is not message one.
    a_time_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_message_one) |-> (o_m1_time_ms == 32'h0000_0000))
        else $error("m1_time_ms nonzero for a frame that is not message one");

    // A byte that is not the last of its frame never stalls in the input register.
    a_mid_byte_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_valid && !stage_item.last_byte) |-> advance)
        else $error("mid-frame byte stalled");

    // A completed last byte is visible as a result in the next cycle.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && stage_item.last_byte) |=> o_out_valid)
        else $error("last byte produced no result");
`endif

endmodule
`default_nettype wire
